/* design/wfsc_pkg.sv */
// Package for the wall-following steering controller.
// Holds the command and mode codes, the request, result and state types
// and the register reset values. Depends on nothing.
`default_nettype none

package wfsc_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_UP    = 3'd1,
    CMD_DOWN  = 3'd2,
    CMD_LEFT  = 3'd3,
    CMD_RIGHT = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_TURN = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_INSTANT_MODE  = 2'd0,
    REG_CRUISE_LIMIT  = 2'd1,
    REG_INSTANT_SPEED = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  localparam int unsigned HeadingW = 9;
  localparam int unsigned TargetW  = 10;
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned ScoreW   = 3;
  localparam int unsigned OvrW     = 7;
  localparam int unsigned CfgDataW = 7;

  localparam logic [TargetW-1:0] TurnStep    = 10'd90;
  localparam logic [TargetW-1:0] FullCircle  = 10'd360;
  localparam logic [TargetW-1:0] HalfCircle  = 10'd180;
  localparam logic [TargetW-1:0] TargetNone  = 10'h3FF;

  localparam logic [OvrW-1:0] CruiseLimitReset  = 7'd4;
  localparam logic [OvrW-1:0] InstantSpeedReset = 7'd21;

  typedef struct packed {
    logic                instant_mode;
    logic [OvrW-1:0]     cruise_speed_limit;
    logic [OvrW-1:0]     instant_speed_value;
  } cfg_t;

  typedef struct packed {
    logic [HeadingW-1:0] heading_deg;
    logic [SpeedW-1:0]   current_speed;
    logic [ScoreW-1:0]   front_left_score;
    logic [ScoreW-1:0]   right_rear_score;
  } item_t;

  typedef struct packed {
    cmd_t                drive_command;
    logic                speed_override_valid;
    logic [OvrW-1:0]     speed_override;
  } result_t;

  typedef struct packed {
    logic                start_pending;
    mode_t               motion_mode;
    logic [TargetW-1:0]  target_heading;
    logic                arrived_flag;
    logic                right_opening_seen;
    logic                right_turn_done;
    cmd_t                held_command;
  } state_t;

  localparam state_t StateReset = '{
    start_pending:      1'b1,
    motion_mode:        MODE_STOP,
    target_heading:     TargetNone,
    arrived_flag:       1'b0,
    right_opening_seen: 1'b0,
    right_turn_done:    1'b1,
    held_command:       CMD_NONE
  };

endpackage

`default_nettype wire

/* design/wfsc_if.sv */
// Handshake channels of the wall-following steering controller.
// One interface for the request channel and one for the result channel;
// depends on nothing.
`default_nettype none

interface wfsc_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] heading_deg;
  logic [7:0] current_speed;
  logic [2:0] front_left_score;
  logic [2:0] right_rear_score;

  modport source (output valid, output heading_deg, output current_speed,
                  output front_left_score, output right_rear_score, input ready);
  modport sink   (input valid, input heading_deg, input current_speed,
                  input front_left_score, input right_rear_score, output ready);
endinterface

interface wfsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] drive_command;
  logic       speed_override_valid;
  logic [6:0] speed_override;

  modport source (output valid, output drive_command, output speed_override_valid,
                  output speed_override, input ready);
  modport sink   (input valid, input drive_command, input speed_override_valid,
                  input speed_override, output ready);
endinterface

`default_nettype wire

/* design/wfsc_cfg.sv */
// Configuration register bank of the steering controller.
// Uses wfsc_pkg for the register indexes and reset values.
`default_nettype none

module wfsc_cfg
  import wfsc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.instant_mode        <= 1'b0;
      cfg_r.cruise_speed_limit  <= CruiseLimitReset;
      cfg_r.instant_speed_value <= InstantSpeedReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_INSTANT_MODE:  cfg_r.instant_mode        <= cfg_wdata[0];
        REG_CRUISE_LIMIT:  cfg_r.cruise_speed_limit  <= cfg_wdata;
        REG_INSTANT_SPEED: cfg_r.instant_speed_value <= cfg_wdata;
        REG_UNUSED:        ;
        default:           ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* design/wfsc_decide.sv */
// Decision logic of the steering controller: one tick's rules applied in order.
// Purely combinational; uses wfsc_pkg for codes, types and constants.
`default_nettype none

module wfsc_decide
  import wfsc_pkg::*;
(
  input  wire cfg_t   cfg,
  input  wire item_t  item,
  input  wire state_t state,
  output state_t      state_nxt,
  output result_t     result
);

  function automatic logic [TargetW-1:0] heading_plus(input logic [HeadingW-1:0] h);
    logic [TargetW-1:0] t;
    t = {1'b0, h} + TurnStep;
    if (t >= FullCircle) begin
      t = t - FullCircle;
    end
    return t;
  endfunction

  function automatic logic [TargetW-1:0] heading_minus(input logic [HeadingW-1:0] h);
    logic [TargetW-1:0] t;
    if ({1'b0, h} < TurnStep) begin
      t = {1'b0, h} + FullCircle - TurnStep;
    end else begin
      t = {1'b0, h} - TurnStep;
    end
    return t;
  endfunction

  always_comb begin
    state_t             s;
    cmd_t               dir;
    logic               ovr_valid;
    logic [OvrW-1:0]    ovr;
    logic signed [TargetW-1:0] hd;
    logic signed [TargetW-1:0] tgt;
    logic               fl_seen;
    logic               rr_seen;
    logic               fast;

    s         = state;
    ovr_valid = 1'b0;
    ovr       = '0;
    fl_seen   = (item.front_left_score != '0);
    rr_seen   = (item.right_rear_score != '0);
    fast      = $signed({item.current_speed[SpeedW-1], item.current_speed})
                >= $signed({2'b00, cfg.cruise_speed_limit});

    // In cruise mode a held accelerate or brake persists until the speed limit is reached.
    dir = CMD_NONE;
    if (!cfg.instant_mode && (s.held_command == CMD_UP || s.held_command == CMD_DOWN)
        && !fast) begin
      dir = s.held_command;
    end

    hd = $signed({1'b0, item.heading_deg});

    tgt = $signed(s.target_heading);
    if (hd == tgt && !s.arrived_flag) begin
      s.start_pending      = 1'b0;
      s.motion_mode        = MODE_STOP;
      s.arrived_flag       = 1'b1;
      s.right_opening_seen = 1'b0;
    end

    if (s.motion_mode == MODE_TURN && !s.arrived_flag) begin
      if (s.target_heading == '0) begin
        dir = (hd > $signed(HalfCircle)) ? CMD_RIGHT : CMD_LEFT;
      end else if (hd < tgt) begin
        dir = CMD_RIGHT;
      end else if (hd > tgt) begin
        dir = CMD_LEFT;
      end
    end

    if (s.start_pending) begin
      if (!fl_seen && !rr_seen) begin
        s.target_heading = heading_plus(item.heading_deg);
        s.motion_mode    = MODE_TURN;
        s.arrived_flag   = 1'b0;
        s.start_pending  = 1'b0;
      end
    end else begin
      if (s.motion_mode == MODE_STOP) begin
        if (!fl_seen && !rr_seen) begin
          if (s.right_opening_seen && !s.right_turn_done) begin
            s.target_heading  = heading_plus(item.heading_deg);
            s.motion_mode     = MODE_TURN;
            s.arrived_flag    = 1'b0;
            s.right_turn_done = 1'b1;
          end else begin
            if (cfg.instant_mode) begin
              ovr_valid = 1'b1;
              ovr       = cfg.instant_speed_value;
            end else begin
              dir = CMD_UP;
            end
            s.motion_mode = MODE_MOVE;
          end
        end else if (fl_seen) begin
          dir              = CMD_LEFT;
          s.target_heading = heading_minus(item.heading_deg);
          s.motion_mode    = MODE_TURN;
          s.arrived_flag   = 1'b0;
        end else begin
          if (cfg.instant_mode) begin
            ovr_valid = 1'b1;
            ovr       = cfg.instant_speed_value;
          end
          dir           = CMD_UP;
          s.motion_mode = MODE_MOVE;
        end
      end
      // The moving check runs in the same tick, so a start just made may stop at once.
      if (s.motion_mode == MODE_MOVE) begin
        if (!rr_seen && !s.right_turn_done) begin
          if (cfg.instant_mode) begin
            ovr_valid = 1'b1;
            ovr       = '0;
          end else begin
            dir = CMD_DOWN;
          end
          s.motion_mode        = MODE_STOP;
          s.right_opening_seen = 1'b1;
        end else if (fl_seen) begin
          if (cfg.instant_mode) begin
            ovr_valid = 1'b1;
            ovr       = '0;
          end else begin
            dir = CMD_DOWN;
          end
          s.motion_mode = MODE_STOP;
        end else if (rr_seen) begin
          s.right_turn_done = 1'b0;
        end
      end
    end

    s.held_command = dir;

    state_nxt                   = s;
    result.drive_command        = dir;
    result.speed_override_valid = ovr_valid;
    result.speed_override       = ovr;
  end

endmodule

`default_nettype wire

/* design/wall_follow_steering_controller.sv */
// Wall-following steering controller, top level.
// An accepted request is stored in the request register, then decided into the result register.
// Throughput: one request per cycle while the sink takes results, set by the single
// decision stage between the request register and the result register.
// Reset (rst_n, synchronous, active low) clears both stages, restores the
// steering state and loads the configuration reset values; no clearing pass.
`default_nettype none

module wall_follow_steering_controller
  import wfsc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  wfsc_in_if.sink                  in_req,
  wfsc_out_if.source               out_res,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   item_r;
  logic    req_valid_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t result_nxt;
  result_t result_r;
  logic    out_valid_r;
  logic    req_advance;
  logic    in_accept;

  wfsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The registered request is decided and moved into the result register
  // whenever that register is empty or being emptied this cycle. The steering
  // state advances at the same edge, so the next request sees it at once.
  assign req_advance  = req_valid_r && (!out_valid_r || out_res.ready);

  // A new request may enter while the stored one is leaving, which keeps a
  // steady stream at one request per cycle while the sink takes each waiting result.
  assign in_req.ready = !req_valid_r || req_advance;
  assign in_accept    = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      req_valid_r <= in_req.valid;
    end
  end

  // The payload needs no reset; it is only used when its valid bit is set.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.heading_deg      <= in_req.heading_deg;
      item_r.current_speed    <= in_req.current_speed;
      item_r.front_left_score <= in_req.front_left_score;
      item_r.right_rear_score <= in_req.right_rear_score;
    end
  end

  wfsc_decide u_decide (
    .cfg       (cfg),
    .item      (item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StateReset;
    end else if (req_advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register: holds a finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_res.valid                = out_valid_r;
  assign out_res.drive_command        = result_r.drive_command;
  assign out_res.speed_override_valid = result_r.speed_override_valid;
  assign out_res.speed_override       = result_r.speed_override;

  // Every turn clears the arrival flag and arrival always stops the robot,
  // so the two can never be seen together.
  a_no_turn_when_arrived : assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.arrived_flag && state_r.motion_mode == MODE_TURN))
    else $error("arrival flag set while turning");

  // The target is either unset or a heading reduced once around the circle.
  a_target_range : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.target_heading == TargetNone || state_r.target_heading < 10'd422)
    else $error("target heading out of range");

  // A decided request always lands in the result register.
  a_advance_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    req_advance |=> out_valid_r)
    else $error("decided request lost");

  // Without an override the override speed field reads as zero.
  a_override_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !result_r.speed_override_valid) |-> result_r.speed_override == '0)
    else $error("override speed set without its valid bit");

  // The steering state only moves when a request is decided.
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(req_advance) |-> $stable(state_r))
    else $error("steering state changed without a request");

endmodule

`default_nettype wire
